### src/imat_pkg.sv
// ----------------------------------------------------------------------------
// imat_pkg
// Shared constants, register indexes and helper functions for the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package imat_pkg;

    localparam int InWidth    = 200;
    localparam int OutWidth   = 216;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 24;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_TAU      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GRAVITY  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_BAND_XY  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BAND_Z   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_STILL    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_WARMUP   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_STEP     = 3'd6;

    localparam logic [15:0] TAU_RST      = 16'd8500;
    localparam logic [20:0] GRAVITY_RST  = 21'd642908;
    localparam logic [15:0] BAND_XY_RST  = 16'd1638;
    localparam logic [15:0] BAND_Z_RST   = 16'd2949;
    localparam logic [7:0]  STILL_RST    = 8'd10;
    localparam logic [7:0]  WARMUP_RST   = 8'd30;
    localparam logic [23:0] STEP_RST     = 24'd16777;

    localparam logic signed [19:0] PI_Q16     = 20'sd205887;
    localparam logic signed [24:0] TWO_PI_Q16 = 25'sd411775;
    localparam logic signed [34:0] ONE_Q28    = 35'sd268435456;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // Quaternion product schedule: 01 02 03 11 12 13 22 23 33.
    function automatic logic [1:0] qq_a(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7:       r = 2'd2;
            default:          r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] qq_b(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd3:       r = 2'd1;
            4'd1, 4'd4, 4'd6: r = 2'd2;
            default:          r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/imu_motion_accel_tracker.sv
// ----------------------------------------------------------------------------
// imu_motion_accel_tracker
// Gravity-compensated linear acceleration, integration and yaw unwrapping.
// ----------------------------------------------------------------------------
// An item enters on the s_axis channel (quaternion, body acceleration, step
// time and yaw) and one result item leaves on the m_axis channel for every
// input item. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. All arithmetic runs through one
// shared 34 x 25 bit signed multiplier with an accumulator and a radix-2
// restoring divider, stepped by a sequencer. An item steps through the
// quaternion products and the gravity terms, then per axis a multiply, a
// multiply-accumulate, the divide and a write-back (skipped when tau plus dt
// is zero), then the rotation, a post step and, after warm-up, the speed,
// distance and yaw steps. s_axis_tready is high only while idle, so a new
// item can be taken the cycle after the previous result is accepted.
// The result stays on m_axis_tdata while m_axis_tready is low; the block
// waits for it. Reset clears all filter, counter and integrator state and
// restores the configuration registers to their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_motion_accel_tracker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
    // step_time_us, yaw_angle, zero fill
    input  wire logic [imat_pkg::InWidth-1:0]  s_axis_tdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // motion_x, motion_y, motion_z, speed, distance, yaw_total, ready_res,
    // zero fill
    output logic [imat_pkg::OutWidth-1:0]      m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          cfg_we,
    input  wire logic [imat_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [imat_pkg::CfgDataW-1:0] cfg_data
);
    import imat_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_QQ   = 13'b0000000000010,
        S_GRAV = 13'b0000000000100,
        S_FMUL = 13'b0000000001000,
        S_FACC = 13'b0000000010000,
        S_DIV  = 13'b0000000100000,
        S_FWB  = 13'b0000001000000,
        S_ROT  = 13'b0000010000000,
        S_POST = 13'b0000100000000,
        S_VEL  = 13'b0001000000000,
        S_POS  = 13'b0010000000000,
        S_YAW  = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [15:0] tau_reg;
    logic [20:0] grav_reg;
    logic [15:0] band_xy_reg, band_z_reg;
    logic [7:0]  still_lim_reg, warmup_reg;
    logic [23:0] step_reg;

    // Sequencer counters.
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] ax_reg, ax_next;
    logic [1:0] col_reg, col_next;
    logic [5:0] dcnt_reg, dcnt_next;

    // Persistent state.
    logic signed [31:0] f_reg [3];
    logic signed [31:0] f_next [3];
    logic [7:0]  sc_reg, sc_next, wc_reg, wc_next;
    logic signed [31:0] v_reg, v_next, pos_reg, pos_next;
    logic signed [18:0] prev_reg, prev_next;
    logic signed [15:0] turn_reg, turn_next;
    logic signed [47:0] held_reg, held_next;
    logic ready_reg, ready_next;

    // Item payload and working registers.
    logic signed [15:0] q_reg [4];
    logic signed [31:0] a_reg [3];
    logic [15:0] dt_reg;
    logic signed [18:0] yaw_reg;
    logic signed [31:0] pq_reg [9];
    logic signed [31:0] gb_reg [3];
    logic signed [31:0] gb_next [3];
    logic signed [31:0] mn_reg [3];
    logic signed [31:0] mn_next [3];
    logic signed [63:0] acc_reg, acc_next;
    logic [50:0] dvd_reg, dvd_next;
    logic [16:0] rem_reg, rem_next;
    logic neg_reg, neg_next;

    // Rotation matrix, Q16, from the stored quaternion products.
    logic signed [34:0] pw [9];
    logic signed [34:0] r28 [9];
    logic signed [22:0] rm [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            pw[k] = 35'(pq_reg[k]) <<< 1;
        r28[0] = ONE_Q28 - pw[6] - pw[8];
        r28[1] = (pw[4] - pw[2]);
        r28[2] = (pw[5] + pw[1]);
        r28[3] = (pw[4] + pw[2]);
        r28[4] = ONE_Q28 - pw[3] - pw[8];
        r28[5] = (pw[7] - pw[0]);
        r28[6] = (pw[5] - pw[1]);
        r28[7] = (pw[7] + pw[0]);
        r28[8] = ONE_Q28 - pw[3] - pw[6];
        for (int k = 0; k < 9; k++)
            rm[k] = r28[k][34:12];
    end

    logic [3:0] rm_idx;
    assign rm_idx = {1'b0, ax_reg, 1'b0} + {2'b00, ax_reg} + {2'b00, col_reg};

    // Shared multiplier.
    logic signed [33:0] ma;
    logic signed [24:0] mb;
    logic signed [58:0] prod;
    logic [16:0] den;
    logic [3:0] gsel;

    assign den  = {1'b0, tau_reg} + {1'b0, dt_reg};
    assign gsel = 4'd6 + {2'b00, ax_reg};

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_QQ:
            begin
                ma = 34'(q_reg[qq_a(cnt_reg)]);
                mb = 25'(q_reg[qq_b(cnt_reg)]);
            end
            S_GRAV:
            begin
                ma = signed'({13'd0, grav_reg});
                mb = 25'(rm[gsel]);
            end
            S_FMUL:
            begin
                ma = 34'(33'(a_reg[ax_reg]) - 33'(gb_reg[ax_reg]));
                mb = signed'({9'd0, dt_reg});
            end
            S_FACC:
            begin
                ma = 34'(f_reg[ax_reg]);
                mb = signed'({9'd0, tau_reg});
            end
            S_ROT:
            begin
                ma = 34'(f_reg[col_reg]);
                mb = 25'(rm[rm_idx]);
            end
            S_VEL:
            begin
                ma = 34'(mn_reg[1]);
                mb = signed'({1'b0, step_reg});
            end
            S_POS:
            begin
                ma = 34'(v_reg);
                mb = signed'({1'b0, step_reg});
            end
            S_YAW:
            begin
                ma = 34'(turn_reg);
                mb = TWO_PI_Q16;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = 59'(ma) * 59'(mb);

    // Working values.
    logic signed [63:0] num, rsum;
    logic [17:0] trial;
    logic [51:0] qmag;
    logic signed [52:0] qsig;
    logic signed [32:0] abs0, abs1, abs2;
    logic zx, zy, zz;
    logic [7:0] sc_inc;
    logic signed [19:0] ydiff;

    always_comb
    begin
        num   = acc_reg + 64'(prod);
        rsum  = ((col_reg == 2'd0) ? 64'sd0 : acc_reg) + 64'(prod);
        trial = {rem_reg, dvd_reg[50]};
        qmag  = {1'b0, dvd_reg};
        qsig  = neg_reg ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
        abs0  = mn_reg[0][31] ? -33'(mn_reg[0]) : 33'(mn_reg[0]);
        abs1  = mn_reg[1][31] ? -33'(mn_reg[1]) : 33'(mn_reg[1]);
        abs2  = mn_reg[2][31] ? -33'(mn_reg[2]) : 33'(mn_reg[2]);
        zx    = abs0 < signed'({17'd0, band_xy_reg});
        zy    = abs1 < signed'({17'd0, band_xy_reg});
        zz    = abs2 < signed'({17'd0, band_z_reg});
        sc_inc = (zz && sc_reg != 8'd255) ? sc_reg + 8'd1 : sc_reg;
        ydiff = 20'(yaw_reg) - 20'(prev_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ax_next    = ax_reg;
        col_next   = col_reg;
        dcnt_next  = dcnt_reg;
        f_next     = f_reg;
        sc_next    = sc_reg;
        wc_next    = wc_reg;
        v_next     = v_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        turn_next  = turn_reg;
        held_next  = held_reg;
        ready_next = ready_reg;
        gb_next    = gb_reg;
        mn_next    = mn_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_QQ;
                    cnt_next   = '0;
                end
            end
            S_QQ:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    state_next = S_GRAV;
                    ax_next    = '0;
                end
            end
            S_GRAV:
            begin
                gb_next[ax_reg] = sat32(64'(prod >>> 16));
                ax_next = ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                begin
                    ax_next  = '0;
                    col_next = '0;
                    state_next = (den != 17'd0) ? S_FMUL : S_ROT;
                end
            end
            S_FMUL:
            begin
                acc_next   = 64'(prod);
                state_next = S_FACC;
            end
            S_FACC:
            begin
                neg_next   = num[63];
                dvd_next   = num[63] ? 51'(-num) : num[50:0];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (trial >= {1'b0, den})
                begin
                    rem_next = 17'(trial - {1'b0, den});
                    dvd_next = {dvd_reg[49:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[16:0];
                    dvd_next = {dvd_reg[49:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd50)
                    state_next = S_FWB;
            end
            S_FWB:
            begin
                f_next[ax_reg] = sat32(64'(qsig));
                ax_next = ax_reg + 2'd1;
                state_next = S_FMUL;
                if (ax_reg == 2'd2)
                begin
                    ax_next    = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                acc_next = rsum;
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd2)
                begin
                    mn_next[ax_reg] = sat32(rsum >>> 16);
                    col_next = '0;
                    ax_next  = ax_reg + 2'd1;
                    if (ax_reg == 2'd2)
                    begin
                        ax_next    = '0;
                        state_next = S_POST;
                    end
                end
            end
            S_POST:
            begin
                if (zx)
                    mn_next[0] = '0;
                if (zy)
                    mn_next[1] = '0;
                if (zz)
                    mn_next[2] = '0;
                sc_next = sc_inc;
                if (sc_inc > still_lim_reg)
                begin
                    sc_next = '0;
                    v_next  = '0;
                end
                if (wc_reg > warmup_reg)
                begin
                    ready_next = 1'b1;
                    if (ydiff > PI_Q16)
                    begin
                        if (turn_reg != -16'sd32768)
                            turn_next = turn_reg - 16'sd1;
                    end
                    else if (ydiff < -PI_Q16)
                    begin
                        if (turn_reg != 16'sd32767)
                            turn_next = turn_reg + 16'sd1;
                    end
                    state_next = S_VEL;
                end
                else
                begin
                    if (wc_reg != 8'd255)
                        wc_next = wc_reg + 8'd1;
                    state_next = S_OUT;
                end
            end
            S_VEL:
            begin
                v_next = sat32(64'(v_reg) + 64'(prod >>> 24));
                state_next = S_POS;
            end
            S_POS:
            begin
                pos_next = sat32(64'(pos_reg) + 64'(prod >>> 24));
                state_next = S_YAW;
            end
            S_YAW:
            begin
                held_next  = prod[47:0] + 48'(yaw_reg);
                prev_next  = yaw_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ax_reg        <= '0;
            col_reg       <= '0;
            dcnt_reg      <= '0;
            for (int k = 0; k < 3; k++)
                f_reg[k] <= '0;
            sc_reg        <= '0;
            wc_reg        <= '0;
            v_reg         <= '0;
            pos_reg       <= '0;
            prev_reg      <= '0;
            turn_reg      <= '0;
            held_reg      <= '0;
            ready_reg     <= 1'b0;
            tau_reg       <= TAU_RST;
            grav_reg      <= GRAVITY_RST;
            band_xy_reg   <= BAND_XY_RST;
            band_z_reg    <= BAND_Z_RST;
            still_lim_reg <= STILL_RST;
            warmup_reg    <= WARMUP_RST;
            step_reg      <= STEP_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ax_reg    <= ax_next;
            col_reg   <= col_next;
            dcnt_reg  <= dcnt_next;
            f_reg     <= f_next;
            sc_reg    <= sc_next;
            wc_reg    <= wc_next;
            v_reg     <= v_next;
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            turn_reg  <= turn_next;
            held_reg  <= held_next;
            ready_reg <= ready_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TAU:     tau_reg       <= cfg_data[15:0];
                    REG_GRAVITY: grav_reg      <= cfg_data[20:0];
                    REG_BAND_XY: band_xy_reg   <= cfg_data[15:0];
                    REG_BAND_Z:  band_z_reg    <= cfg_data[15:0];
                    REG_STILL:   still_lim_reg <= cfg_data[7:0];
                    REG_WARMUP:  warmup_reg    <= cfg_data[7:0];
                    REG_STEP:    step_reg      <= cfg_data[23:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            q_reg[0] <= s_axis_tdata[15:0];
            q_reg[1] <= s_axis_tdata[31:16];
            q_reg[2] <= s_axis_tdata[47:32];
            q_reg[3] <= s_axis_tdata[63:48];
            a_reg[0] <= s_axis_tdata[95:64];
            a_reg[1] <= s_axis_tdata[127:96];
            a_reg[2] <= s_axis_tdata[159:128];
            dt_reg   <= s_axis_tdata[175:160];
            yaw_reg  <= s_axis_tdata[194:176];
        end
        if (state_reg == S_QQ)
            pq_reg[cnt_reg] <= prod[31:0];
        gb_reg  <= gb_next;
        mn_reg  <= mn_next;
        acc_reg <= acc_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {7'd0, ready_reg, held_reg, pos_reg, v_reg,
                            mn_reg[2], mn_reg[1], mn_reg[0]};

endmodule

`default_nettype wire

### src/imat_checker.sv
// ----------------------------------------------------------------------------
// imat_checker
// Port-level checks for the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imat_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [imat_pkg::OutWidth-1:0] m_axis_tdata,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready
);
    // The block works on one item at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !m_axis_tvalid))
        else $error("block not busy after taking an item");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after result delivered");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind imu_motion_accel_tracker imat_checker u_imat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Motion acceleration tracker testbench
// Drives attitude, acceleration and yaw items into the tracker. Each accepted
// item goes through a bit-exact predictor of gravity removal, low-pass
// filtering, the dead bands, the still and warm-up counters, speed and
// distance integration and yaw unwrapping. The results are checked field by
// field against the predicted ones. The run covers several register settings,
// including the extremes, and both sides of the stream idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import imat_pkg::*;

    localparam int StallLimit = 6000;

    typedef struct {
        logic signed [15:0] qw, qx, qy, qz;
        logic signed [31:0] ax, ay, az;
        logic [15:0]        dt;
        logic signed [18:0] yaw;
    } sample_t;

    typedef struct {
        logic signed [31:0] mx, my, mz, speed, travel;
        logic signed [47:0] yaw_total;
        logic               ready;
    } motion_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [InWidth-1:0]   s_axis_tdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [OutWidth-1:0]  m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data = '0;

    imu_motion_accel_tracker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Register copies and tracker state of the predictor.
    longint tau_us, gravity, band_xy, band_z, still_max, warmup_max, int_step;
    longint filt [3];
    longint still_cnt, warm_cnt, velocity, position, last_yaw, turns, yaw_sum;
    bit     is_ready;

    motion_t expected_motion [$];
    int      n_errors = 0;
    int      n_items = 0;
    int      n_results = 0;
    int      n_still_clears = 0;
    int      n_wraps = 0;
    bit      free_running = 1'b0;
    int      stall_left = 0;
    int      idle_cycles = 0;
    longint  yaw_walk = 0;

    function automatic longint sat_word(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint abs_val(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic motion_t track_motion(input sample_t s);
        longint  q0, q1, q2, q3, dt, yaw, num, sum, diff;
        longint  a [3];
        longint  gb [3];
        longint  mn [3];
        longint  rm [3][3];
        motion_t r;
        q0 = 64'(s.qw); q1 = 64'(s.qx); q2 = 64'(s.qy); q3 = 64'(s.qz);
        a[0] = 64'(s.ax); a[1] = 64'(s.ay); a[2] = 64'(s.az);
        dt = 64'(s.dt);
        yaw = 64'(s.yaw);
        rm[0][0] = (64'sd1 <<< 28) - 2 * q2 * q2 - 2 * q3 * q3;
        rm[0][1] = 2 * (q1 * q2 - q0 * q3);
        rm[0][2] = 2 * (q1 * q3 + q0 * q2);
        rm[1][0] = 2 * (q1 * q2 + q0 * q3);
        rm[1][1] = (64'sd1 <<< 28) - 2 * q1 * q1 - 2 * q3 * q3;
        rm[1][2] = 2 * (q2 * q3 - q0 * q1);
        rm[2][0] = 2 * (q1 * q3 - q0 * q2);
        rm[2][1] = 2 * (q2 * q3 + q0 * q1);
        rm[2][2] = (64'sd1 <<< 28) - 2 * q1 * q1 - 2 * q2 * q2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rm[i][j] = rm[i][j] >>> 12;
        for (int i = 0; i < 3; i++)
            gb[i] = sat_word((rm[2][i] * gravity) >>> 16);
        // With no time base at all the filter simply holds.
        if (tau_us + dt != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num = (a[i] - gb[i]) * dt + filt[i] * tau_us;
                filt[i] = sat_word(num / (tau_us + dt));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            sum = 0;
            for (int j = 0; j < 3; j++)
                sum += rm[i][j] * filt[j];
            mn[i] = sat_word(sum >>> 16);
        end
        if (abs_val(mn[0]) < band_xy)
            mn[0] = 0;
        if (abs_val(mn[1]) < band_xy)
            mn[1] = 0;
        if (abs_val(mn[2]) < band_z)
        begin
            mn[2] = 0;
            if (still_cnt < 255)
                still_cnt++;
        end
        if (still_cnt > still_max)
        begin
            still_cnt = 0;
            velocity = 0;
            n_still_clears++;
        end
        if (warm_cnt > warmup_max)
        begin
            velocity = sat_word(velocity + ((mn[1] * int_step) >>> 24));
            position = sat_word(position + ((velocity * int_step) >>> 24));
            is_ready = 1'b1;
            diff = yaw - last_yaw;
            if (diff > 205887)
            begin
                if (turns > -32768)
                    turns--;
                n_wraps++;
            end
            else if (diff < -205887)
            begin
                if (turns < 32767)
                    turns++;
                n_wraps++;
            end
            yaw_sum = turns * 411775 + yaw;
            last_yaw = yaw;
        end
        else if (warm_cnt < 255)
        begin
            warm_cnt++;
        end
        r.mx = mn[0][31:0];
        r.my = mn[1][31:0];
        r.mz = mn[2][31:0];
        r.speed = velocity[31:0];
        r.travel = position[31:0];
        r.yaw_total = yaw_sum[47:0];
        r.ready = is_ready;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("ERROR: result %0d field %s: got %0d, expected %0d",
                 n_results, field, got, want);
        n_errors++;
    endtask

    // Predict on every accepted item.
    always @(posedge clk)
    begin
        sample_t s;
        if (s_axis_tvalid && s_axis_tready)
        begin
            s.qw  = s_axis_tdata[15:0];
            s.qx  = s_axis_tdata[31:16];
            s.qy  = s_axis_tdata[47:32];
            s.qz  = s_axis_tdata[63:48];
            s.ax  = s_axis_tdata[95:64];
            s.ay  = s_axis_tdata[127:96];
            s.az  = s_axis_tdata[159:128];
            s.dt  = s_axis_tdata[175:160];
            s.yaw = s_axis_tdata[194:176];
            expected_motion.push_back(track_motion(s));
            n_items++;
        end
    end

    // Check every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        motion_t w;
        motion_t g;
        if (m_axis_tvalid && m_axis_tready)
        begin
            g.mx        = m_axis_tdata[31:0];
            g.my        = m_axis_tdata[63:32];
            g.mz        = m_axis_tdata[95:64];
            g.speed     = m_axis_tdata[127:96];
            g.travel    = m_axis_tdata[159:128];
            g.yaw_total = m_axis_tdata[207:160];
            g.ready     = m_axis_tdata[208];
            if (expected_motion.size() == 0)
            begin
                $display("ERROR: result %0d arrived with none expected", n_results);
                n_errors++;
            end
            else
            begin
                w = expected_motion.pop_front();
                if (g.mx != w.mx)
                    report_mismatch("motion_x", g.mx, w.mx);
                if (g.my != w.my)
                    report_mismatch("motion_y", g.my, w.my);
                if (g.mz != w.mz)
                    report_mismatch("motion_z", g.mz, w.mz);
                if (g.speed != w.speed)
                    report_mismatch("speed", g.speed, w.speed);
                if (g.travel != w.travel)
                    report_mismatch("distance", g.travel, w.travel);
                if (g.yaw_total != w.yaw_total)
                    report_mismatch("yaw_total", g.yaw_total, w.yaw_total);
                if (g.ready != w.ready)
                    report_mismatch("ready_res", g.ready, w.ready);
            end
            n_results++;
        end
    end

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(posedge clk)
    begin
        if (free_running)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(30, 150)
                                                       : $urandom_range(0, 4);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("ERROR: no handshake for %0d cycles", StallLimit);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_sample(input sample_t s);
        int gap;
        gap = free_running ? 0 :
              ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, s.yaw, s.dt, s.az, s.ay, s.ax, s.qz, s.qy, s.qx, s.qw};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_motion.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Only called while the tracker is idle.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CfgDataW-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_TAU:     tau_us     = value & 64'hFFFF;
            REG_GRAVITY: gravity    = value & 64'h1FFFFF;
            REG_BAND_XY: band_xy    = value & 64'hFFFF;
            REG_BAND_Z:  band_z     = value & 64'hFFFF;
            REG_STILL:   still_max  = value & 64'hFF;
            REG_WARMUP:  warmup_max = value & 64'hFF;
            REG_STEP:    int_step   = value & 64'hFFFFFF;
            default:     ;
        endcase
    endtask

    task automatic write_all(input longint t, input longint g, input longint bxy,
                             input longint bz, input longint sl, input longint wu,
                             input longint st);
        write_reg(REG_TAU, t);
        write_reg(REG_GRAVITY, g);
        write_reg(REG_BAND_XY, bxy);
        write_reg(REG_BAND_Z, bz);
        write_reg(REG_STILL, sl);
        write_reg(REG_WARMUP, wu);
        write_reg(REG_STEP, st);
    endtask

    function automatic sample_t level_sample(input longint yaw);
        sample_t s;
        s.qw = 16'sd16384; s.qx = '0; s.qy = '0; s.qz = '0;
        s.ax = '0; s.ay = '0; s.az = gravity[31:0];
        s.dt = 16'd1000;
        s.yaw = yaw[18:0];
        return s;
    endfunction

    // Mostly near-unit attitudes, realistic accelerations and a wandering yaw;
    // about one item in eight is drawn over the full field ranges.
    function automatic sample_t random_sample();
        sample_t s;
        if ($urandom_range(0, 7) == 0)
        begin
            s.qw = 16'($urandom); s.qx = 16'($urandom);
            s.qy = 16'($urandom); s.qz = 16'($urandom);
            s.ax = $urandom; s.ay = $urandom; s.az = $urandom;
            s.dt = 16'($urandom);
            s.yaw = 19'($urandom_range(0, 411776) - 205888);
        end
        else
        begin
            s.qw = 16'(16384 - $urandom_range(0, 1500));
            s.qx = 16'($urandom_range(0, 6000) - 3000);
            s.qy = 16'($urandom_range(0, 6000) - 3000);
            s.qz = 16'($urandom_range(0, 12000) - 6000);
            if ($urandom_range(0, 2) == 0)
            begin
                s.ax = $urandom_range(0, 2000) - 1000;
                s.ay = $urandom_range(0, 2000) - 1000;
                s.az = 32'(gravity + $urandom_range(0, 2000) - 1000);
            end
            else
            begin
                s.ax = $urandom_range(0, 2000000) - 1000000;
                s.ay = $urandom_range(0, 2000000) - 1000000;
                s.az = 32'(gravity + $urandom_range(0, 2000000) - 1000000);
            end
            s.dt = 16'($urandom_range(500, 1500));
            yaw_walk += $urandom_range(0, 60000) - 30000;
            if (yaw_walk > 205888)
                yaw_walk -= 411775;
            if (yaw_walk < -205888)
                yaw_walk += 411775;
            s.yaw = yaw_walk[18:0];
        end
        return s;
    endfunction

    task automatic test_directed();
        sample_t s;
        // Level and at rest: the still count builds up and clears the speed.
        for (int i = 0; i < 12; i++)
            send_sample(level_sample(0));
        s = level_sample(0);
        s.qw = 16'sh7FFF; s.qx = 16'sh8000; s.qy = 16'sh7FFF; s.qz = 16'sh8000;
        send_sample(s);
        s.qw = 16'sh8000; s.qx = 16'sh7FFF; s.qy = 16'sh8000; s.qz = 16'sh7FFF;
        s.ax = 32'h7FFFFFFF; s.ay = 32'h80000000; s.az = 32'h7FFFFFFF;
        s.dt = 16'hFFFF;
        send_sample(s);
        s.ax = 32'h80000000; s.ay = 32'h7FFFFFFF; s.az = 32'h80000000;
        send_sample(s);
        s = level_sample(0);
        s.dt = '0;
        send_sample(s);
        drain_results();
        // Past warm-up with short settings, then yaw wraps both ways.
        write_reg(REG_WARMUP, 0);
        write_reg(REG_STILL, 0);
        send_sample(level_sample(0));
        send_sample(level_sample(205888));
        send_sample(level_sample(-205888));
        send_sample(level_sample(205888));
        send_sample(level_sample(-1));
        send_sample(level_sample(205887));
        drain_results();
        // No time base at all: the filter holds.
        write_reg(REG_TAU, 0);
        s = level_sample(0);
        s.ay = 200000;
        s.dt = '0;
        send_sample(s);
        send_sample(s);
        drain_results();
    endtask

    task automatic test_random_phase(input int count, input bit sync_mid);
        sample_t s;
        for (int i = 0; i < count; i++)
        begin
            // The result side runs without stalls for a stretch of each phase.
            free_running = (i >= 30 && i < 60);
            if (sync_mid && i == count / 2)
            begin
                // Hold off until the tracker has delivered everything.
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_motion.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                for (int k = 0; k < 14 && i < count; k++, i++)
                    send_sample(level_sample(yaw_walk));
            end
            else
            begin
                s = random_sample();
                send_sample(s);
            end
        end
        free_running = 1'b0;
        drain_results();
    endtask

    task automatic test_register_settings();
        write_all(TAU_RST, GRAVITY_RST, BAND_XY_RST, BAND_Z_RST, 5, 20, STEP_RST);
        test_random_phase(220, 1'b1);
        write_all(0, 0, 0, 0, 0, 0, 0);
        test_random_phase(120, 1'b0);
        write_all(65535, 2097151, 65535, 65535, 254, 254, 16777215);
        test_random_phase(160, 1'b0);
        write_all(2000, 642908, 500, 800, 3, 0, 16777215);
        test_random_phase(200, 1'b1);
        write_all($urandom_range(0, 65535), $urandom_range(600000, 700000),
                  $urandom_range(0, 4000), $urandom_range(0, 4000),
                  $urandom_range(0, 20), $urandom_range(0, 40), $urandom_range(0, 16777215));
        test_random_phase(120, 1'b0);
    endtask

    initial
    begin
        tau_us = TAU_RST; gravity = GRAVITY_RST; band_xy = BAND_XY_RST;
        band_z = BAND_Z_RST; still_max = STILL_RST; warmup_max = WARMUP_RST;
        int_step = STEP_RST;
        filt[0] = 0; filt[1] = 0; filt[2] = 0;
        still_cnt = 0; warm_cnt = 0; velocity = 0; position = 0;
        last_yaw = 0; turns = 0; yaw_sum = 0; is_ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_settings();
        repeat (200) @(posedge clk);
        $display("Covered %0d items and %0d results over eight register settings,",
                 n_items, n_results);
        $display("with %0d still clears and %0d yaw wraps.", n_still_clears, n_wraps);
        if (n_errors == 0 && expected_motion.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
